// File: hdl/csl_pkg.sv
// Shared constants, token record type and keyword lookup for the lexer.
package csl_pkg;

  localparam int MAX_TEXT_CHARS = 63;
  localparam int SOURCE_BYTES   = 8192;
  localparam int POS_W          = $clog2(SOURCE_BYTES);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_SLASH   = 4'd2;
  localparam logic [3:0] M_STRING  = 4'd3;
  localparam logic [3:0] M_STRFULL = 4'd4;
  localparam logic [3:0] M_IDENT   = 4'd5;
  localparam logic [3:0] M_INT     = 4'd6;
  localparam logic [3:0] M_FRAC    = 4'd7;
  localparam logic [3:0] M_OP      = 4'd8;

  localparam logic [5:0] K_TRUE  = 6'd3;
  localparam logic [5:0] K_ID    = 6'd8;
  localparam logic [5:0] K_NUM   = 6'd10;
  localparam logic [5:0] K_DNUM  = 6'd11;
  localparam logic [5:0] K_STR   = 6'd12;
  localparam logic [5:0] K_LPAR  = 6'd13;
  localparam logic [5:0] K_RPAR  = 6'd14;
  localparam logic [5:0] K_LBRC  = 6'd15;
  localparam logic [5:0] K_RBRC  = 6'd16;
  localparam logic [5:0] K_SEMI  = 6'd17;
  localparam logic [5:0] K_MUL   = 6'd21;
  localparam logic [5:0] K_DIV   = 6'd22;
  localparam logic [5:0] K_COMMA = 6'd33;
  localparam logic [5:0] K_EOF   = 6'd34;
  localparam logic [5:0] K_ERR   = 6'd35;

  typedef struct packed {
    logic [5:0]        kind;
    logic signed [31:0] value;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  length;
    logic [15:0]       line;
    logic              last;
  } tok_t;

  localparam logic [47:0] KW_WORD [15] = '{
    "int", "double", "bool", "true", "false", "void", "string", "main",
    "input", "if", "else", "while", "for", "return", "exit"};
  localparam logic [2:0] KW_LEN [15] = '{
    3'd3, 3'd6, 3'd4, 3'd4, 3'd5, 3'd4, 3'd6, 3'd4,
    3'd5, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd4};
  localparam logic [5:0] KW_KIND [15] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
    6'd9, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41};

  // Kind of an identifier: keyword kind on an exact match, else K_ID.
  function automatic logic [5:0] kw_kind(input logic [47:0] window, input logic [5:0] count);
    logic [5:0] k;
    k = K_ID;
    for (int i = 14; i >= 0; i--) begin
      if (count == {3'd0, KW_LEN[i]} && window == KW_WORD[i]) k = KW_KIND[i];
    end
    return k;
  endfunction

endpackage

// File: hdl/csl_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface csl_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        token_kind;
  logic signed [31:0] token_value;
  logic [12:0]       token_start;
  logic [12:0]       token_length;
  logic [15:0]       line_number;
  logic              last_of_run;
  modport source (output valid, output token_kind, output token_value, output token_start,
                  output token_length, output line_number, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_value, input token_start,
                input token_length, input line_number, input last_of_run, output ready);
endinterface

// File: hdl/c_subset_lexer.sv
// Streaming lexer for a small C-like language: one source byte in, up to two tokens out.
// Each accepted byte is lexed by the combinational state update below, and the
// tokens it produces (zero, one or two) are written into a four-entry result queue
// that feeds the output channel one transaction per cycle while the sink is ready.
// A byte is accepted in any cycle in which the queue has room for two tokens, so a
// byte per cycle is sustained as long as the sink takes tokens; the byte stream only
// slows down when tokens pile up faster than the sink drains them. A zero byte flushes
// the pending token, emits an end token and returns the lexer to its reset state.
// Token offsets are byte offsets in the source, saturating at the last position, and
// line numbers count whitespace newlines including the one that closes a line comment.
module c_subset_lexer (
  input  logic clk,
  input  logic rst,
  csl_in_if.sink    in_ch,
  csl_out_if.source out_ch
);
  import csl_pkg::*;

  logic [3:0]        mode, mode_next;
  logic [15:0]       line_cnt, line_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  start_pos, start_next;
  logic [5:0]        text_cnt, text_next;
  logic [47:0]       kw_win, kw_next;
  logic [31:0]       int_acc, int_next;
  logic [19:0]       frac_acc, frac_next;
  logic [2:0]        frac_dig, frac_dig_next;
  logic              esc, esc_next;

  tok_t              tok0, tok1;
  logic              put0, put1;

  tok_t              q_mem [4];
  logic [1:0]        q_rd, q_wr;
  logic [2:0]        q_cnt;

  logic              acc;
  logic [7:0]        c;

  assign acc = in_ch.valid && in_ch.ready;
  assign c = in_ch.char_byte;
  assign in_ch.ready = (q_cnt <= 3'd2);

  function automatic logic [POS_W-1:0] tok_len(input logic [POS_W:0] fin,
                                               input logic [POS_W-1:0] st);
    logic [POS_W:0] d;
    d = (fin >= {1'b0, st}) ? fin - {1'b0, st} : '0;
    return d[POS_W] ? '1 : d[POS_W-1:0];
  endfunction

  function automatic tok_t mk(input logic [5:0] kind, input logic [31:0] val,
                              input logic [POS_W:0] fin, input logic [POS_W-1:0] st,
                              input logic [15:0] ln);
    tok_t t;
    t.kind = kind;
    t.value = val;
    t.start = st;
    t.length = tok_len(fin, st);
    t.line = ln;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [31:0] dec_value(input logic [31:0] ia, input logic [19:0] fa,
                                            input logic [2:0] fd);
    logic [31:0] sc;
    case (fd)
      3'd0: sc = 32'd1000000;
      3'd1: sc = 32'd100000;
      3'd2: sc = 32'd10000;
      3'd3: sc = 32'd1000;
      3'd4: sc = 32'd100;
      3'd5: sc = 32'd10;
      default: sc = 32'd1;
    endcase
    return ia * 32'd1000000 + {12'd0, fa} * sc;
  endfunction

  function automatic logic [5:0] op_single(input logic [2:0] k);
    case (k)
      3'd2: return 6'd18;
      3'd4: return 6'd25;
      3'd5: return 6'd26;
      3'd6: return 6'd19;
      3'd7: return 6'd20;
      default: return K_ERR;
    endcase
  endfunction

  function automatic logic [5:0] op_pair(input logic [2:0] k);
    case (k)
      3'd0: return 6'd29;
      3'd1: return 6'd30;
      3'd2: return 6'd23;
      3'd3: return 6'd24;
      3'd4: return 6'd27;
      3'd5: return 6'd28;
      3'd6: return 6'd31;
      default: return 6'd32;
    endcase
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] k);
    case (k)
      3'd0: return "&";
      3'd1: return "|";
      3'd6: return "+";
      3'd7: return "-";
      default: return "=";
    endcase
  endfunction

  // Main lexing step: a zero byte flushes and resets; else a mode-specific part that may
  // close the pending token, then the shared token-start logic if the byte opens one.
  always_comb begin
    logic          do_begin;
    logic [POS_W:0] pos1;
    logic [5:0]    tc;
    logic [5:0]    ik;
    mode_next = mode;
    line_next = line_cnt;
    pos_next = pos;
    start_next = start_pos;
    text_next = text_cnt;
    kw_next = kw_win;
    int_next = int_acc;
    frac_next = frac_acc;
    frac_dig_next = frac_dig;
    esc_next = esc;
    put0 = 1'b0;
    put1 = 1'b0;
    tok0 = '0;
    tok1 = '0;
    do_begin = 1'b0;
    pos1 = {1'b0, pos} + 1'b1;
    tc = text_cnt + 6'd1;
    ik = kw_kind(kw_win, text_cnt);

    if (c == 8'd0) begin
      // End of text: flush, then the end token at the current offset.
      put0 = 1'b1;
      case (mode)
        M_SLASH: tok0 = mk(K_DIV, '0, {1'b0, pos}, start_pos, line_cnt);
        M_STRING, M_STRFULL: tok0 = mk(K_STR, '0, {1'b0, pos}, start_pos, line_cnt);
        M_IDENT: tok0 = mk(ik, {31'd0, ik == K_TRUE}, {1'b0, pos}, start_pos, line_cnt);
        M_INT: tok0 = mk(K_NUM, int_acc, {1'b0, pos}, start_pos, line_cnt);
        M_FRAC: tok0 = mk(K_DNUM, dec_value(int_acc, frac_acc, frac_dig), {1'b0, pos},
                          start_pos, line_cnt);
        default: begin
          if (mode >= M_OP) tok0 = mk(op_single(mode[2:0]), '0, {1'b0, pos}, start_pos,
                                      line_cnt);
          else put0 = 1'b0;
        end
      endcase
      if (put0) begin
        put1 = 1'b1;
        tok1 = mk(K_EOF, '0, {1'b0, pos}, pos, line_cnt);
      end else begin
        put0 = 1'b1;
        tok0 = mk(K_EOF, '0, {1'b0, pos}, pos, line_cnt);
      end
      mode_next = M_IDLE;
      line_next = 16'd1;
      pos_next = '0;
      start_next = '0;
      text_next = '0;
      kw_next = '0;
      int_next = '0;
      frac_next = '0;
      frac_dig_next = '0;
      esc_next = 1'b0;
    end else begin
      case (mode)
        M_IDLE: do_begin = 1'b1;
        M_COMMENT: begin
          if (c == "\n") begin
            mode_next = M_IDLE;
            do_begin = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_next = M_COMMENT;
          else begin
            put0 = 1'b1;
            tok0 = mk(K_DIV, '0, {1'b0, pos}, start_pos, line_cnt);
            do_begin = 1'b1;
          end
        end
        M_STRING: begin
          logic as_char;
          logic as_full;
          as_char = 1'b0;
          as_full = 1'b0;
          if (esc) begin
            esc_next = 1'b0;
            text_next = tc;
            if (c == "n") begin
              if (tc >= 6'(MAX_TEXT_CHARS)) mode_next = M_STRFULL;
            end else if (tc >= 6'(MAX_TEXT_CHARS)) begin
              as_full = 1'b1;
            end else begin
              as_char = 1'b1;
            end
          end else begin
            as_char = 1'b1;
          end
          if (as_char) begin
            if (c == "\"") begin
              put0 = 1'b1;
              tok0 = mk(K_STR, '0, pos1, start_pos, line_cnt);
              mode_next = M_IDLE;
            end else if (c == "\\") begin
              esc_next = 1'b1;
            end else begin
              text_next = (esc ? tc : text_cnt) + 6'd1;
              if ((esc ? tc : text_cnt) + 6'd1 >= 6'(MAX_TEXT_CHARS)) mode_next = M_STRFULL;
            end
          end
          if (as_full) begin
            put0 = 1'b1;
            if (c == "\"") begin
              tok0 = mk(K_STR, '0, pos1, start_pos, line_cnt);
              mode_next = M_IDLE;
            end else begin
              tok0 = mk(K_STR, '0, {1'b0, pos}, start_pos, line_cnt);
              mode_next = M_IDLE;
              do_begin = 1'b1;
            end
          end
        end
        M_STRFULL: begin
          put0 = 1'b1;
          mode_next = M_IDLE;
          if (c == "\"") tok0 = mk(K_STR, '0, pos1, start_pos, line_cnt);
          else begin
            tok0 = mk(K_STR, '0, {1'b0, pos}, start_pos, line_cnt);
            do_begin = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            logic [47:0] w;
            logic [5:0]  k2;
            text_next = tc;
            w = kw_win;
            if (tc <= 6'd6) w = {kw_win[39:0], c};
            kw_next = w;
            k2 = kw_kind(w, tc);
            if (tc >= 6'(MAX_TEXT_CHARS)) begin
              put0 = 1'b1;
              tok0 = mk(k2, {31'd0, k2 == K_TRUE}, pos1, start_pos, line_cnt);
              mode_next = M_IDLE;
            end
          end else begin
            put0 = 1'b1;
            tok0 = mk(ik, {31'd0, ik == K_TRUE}, {1'b0, pos}, start_pos, line_cnt);
            mode_next = M_IDLE;
            do_begin = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) int_next = int_acc * 32'd10 + {28'd0, c[3:0]};
          else if (c == ".") mode_next = M_FRAC;
          else begin
            put0 = 1'b1;
            tok0 = mk(K_NUM, int_acc, {1'b0, pos}, start_pos, line_cnt);
            mode_next = M_IDLE;
            do_begin = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            if (frac_dig < 3'd6) begin
              frac_next = frac_acc * 20'd10 + {16'd0, c[3:0]};
              frac_dig_next = frac_dig + 3'd1;
            end
          end else begin
            put0 = 1'b1;
            tok0 = mk(K_DNUM, dec_value(int_acc, frac_acc, frac_dig), {1'b0, pos},
                      start_pos, line_cnt);
            mode_next = M_IDLE;
            do_begin = 1'b1;
          end
        end
        default: begin
          put0 = 1'b1;
          mode_next = M_IDLE;
          if (c == op_second(mode[2:0])) begin
            tok0 = mk(op_pair(mode[2:0]), '0, pos1, start_pos, line_cnt);
          end else begin
            tok0 = mk(op_single(mode[2:0]), '0, {1'b0, pos}, start_pos, line_cnt);
            do_begin = 1'b1;
          end
        end
      endcase

      if (do_begin) begin
        tok_t       tb;
        logic       pb;
        logic [5:0] sk;
        pb = 1'b0;
        sk = K_ERR;
        start_next = pos;
        if (c == " " || c == "\r" || c == "\t" || c == "\n") begin
          if (c == "\n" && line_cnt != 16'hFFFF) line_next = line_cnt + 16'd1;
        end else if (c == "/") begin
          mode_next = M_SLASH;
        end else if (c == "\"") begin
          mode_next = M_STRING;
          text_next = '0;
          esc_next = 1'b0;
        end else if (is_digit(c)) begin
          mode_next = M_INT;
          int_next = {28'd0, c[3:0]};
          frac_next = '0;
          frac_dig_next = '0;
        end else if (is_alpha(c)) begin
          mode_next = M_IDENT;
          text_next = 6'd1;
          kw_next = {40'd0, c};
        end else begin
          case (c)
            "&": mode_next = M_OP + 4'd0;
            "|": mode_next = M_OP + 4'd1;
            "=": mode_next = M_OP + 4'd2;
            "!": mode_next = M_OP + 4'd3;
            "<": mode_next = M_OP + 4'd4;
            ">": mode_next = M_OP + 4'd5;
            "+": mode_next = M_OP + 4'd6;
            "-": mode_next = M_OP + 4'd7;
            default: begin
              pb = 1'b1;
              mode_next = M_IDLE;
              case (c)
                "(": sk = K_LPAR;
                ")": sk = K_RPAR;
                "{": sk = K_LBRC;
                "}": sk = K_RBRC;
                ";": sk = K_SEMI;
                ",": sk = K_COMMA;
                "*": sk = K_MUL;
                default: sk = K_ERR;
              endcase
            end
          endcase
        end
        tb = mk(sk, '0, pos1, pos, line_cnt);
        if (pb) begin
          if (put0) begin
            put1 = 1'b1;
            tok1 = tb;
          end else begin
            put0 = 1'b1;
            tok0 = tb;
          end
        end
      end

      if (pos != '1) pos_next = pos + 1'b1;
    end

    if (put1) tok1.last = 1'b1;
    else if (put0) tok0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      line_cnt <= 16'd1;
      pos <= '0;
      start_pos <= '0;
      text_cnt <= '0;
      kw_win <= '0;
      int_acc <= '0;
      frac_acc <= '0;
      frac_dig <= '0;
      esc <= 1'b0;
    end else if (acc) begin
      mode <= mode_next;
      line_cnt <= line_next;
      pos <= pos_next;
      start_pos <= start_next;
      text_cnt <= text_next;
      kw_win <= kw_next;
      int_acc <= int_next;
      frac_acc <= frac_next;
      frac_dig <= frac_dig_next;
      esc <= esc_next;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  logic out_take;
  logic [2:0] n_wr;
  assign out_take = out_ch.valid && out_ch.ready;
  assign n_wr = acc ? ({2'd0, put0} + {2'd0, put1}) : 3'd0;

  always_ff @(posedge clk) begin
    if (acc && put0) q_mem[q_wr] <= tok0;
    if (acc && put1) q_mem[q_wr + 2'd1] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd <= '0;
      q_wr <= '0;
      q_cnt <= '0;
    end else begin
      q_wr <= q_wr + n_wr[1:0];
      if (out_take) q_rd <= q_rd + 2'd1;
      q_cnt <= q_cnt + n_wr - {2'd0, out_take};
    end
  end

  assign out_ch.valid = (q_cnt != 3'd0);
  assign out_ch.token_kind = q_mem[q_rd].kind;
  assign out_ch.token_value = q_mem[q_rd].value;
  assign out_ch.token_start = q_mem[q_rd].start;
  assign out_ch.token_length = q_mem[q_rd].length;
  assign out_ch.line_number = q_mem[q_rd].line;
  assign out_ch.last_of_run = q_mem[q_rd].last;

  // The queue never holds more than its four entries.
  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_cnt <= 3'd4)
    else $error("result queue overflow");

  // An end-of-text byte always leaves at least one token waiting.
  a_eof_out: assert property (@(posedge clk) disable iff (rst)
    (acc && in_ch.char_byte == 8'd0) |=> out_ch.valid)
    else $error("end of text produced no token");

  // The end-of-text byte returns the lexer to idle at the first line.
  a_eof_reset: assert property (@(posedge clk) disable iff (rst)
    (acc && in_ch.char_byte == 8'd0) |=> (mode == M_IDLE && line_cnt == 16'd1 && pos == '0))
    else $error("lexer not reset after end of text");

endmodule
